### src/two_class_exclusive_admission_arbiter_macros.svh
// assertion macros of the admission arbiter rtl
`ifndef TWO_CLASS_EXCLUSIVE_ADMISSION_ARBITER_MACROS_SVH
`define TWO_CLASS_EXCLUSIVE_ADMISSION_ARBITER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TCEA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TCEA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tcea_pkg.sv
// shared types and constants of the admission arbiter
package tcea_pkg;

	localparam int OccW = 5;
	localparam int PortIdW = 8;
	localparam logic [OccW-1:0] CapLimit = 5'd16;
	localparam logic [OccW-1:0] CapReset = 5'd3;

	typedef enum logic {
		CMD_ARRIVE = 1'b0,
		CMD_LEAVE  = 1'b1
	} cmd_e_t;

	typedef enum logic [1:0] {
		EVT_ADMIT       = 2'd0,
		EVT_REJECT      = 2'd1,
		EVT_LEAVE_EMPTY = 2'd2
	} evt_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PLAN,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_cmd_t;

	typedef struct packed {
		logic                valid;
		evt_kind_t           kind;
		logic [PortIdW-1:0]  id;
		logic                cls;
		logic                last;
	} emit_t;

endpackage

### src/tcea_fifo.sv
// requester id queue of one class: memory, head pointer and fill count
module tcea_fifo import tcea_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH = 8,
	localparam int IdxW = $clog2(QUEUE_DEPTH),
	localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fifo_cmd_t           cmd,
	input  logic [ID_WIDTH-1:0] wr_id,
	output logic [CntW-1:0]     count,
	output logic [ID_WIDTH-1:0] rd_id
);

	localparam int SumW = IdxW + 1;

	logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [IdxW-1:0]     head_q;
	logic [CntW-1:0]     count_q;
	logic [ID_WIDTH-1:0] rd_q;
	logic [SumW-1:0]     tail_sum;
	logic [IdxW-1:0]     tail_idx;

	// tail position wraps with one compare and subtract
	assign tail_sum = SumW'(head_q) + SumW'(count_q);
	assign tail_idx = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
		IdxW'(tail_sum - SumW'(QUEUE_DEPTH)) : IdxW'(tail_sum);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_idx] <= wr_id;
		end
		if (cmd.pop) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q  <= (head_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end else if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign count = count_q;
	assign rd_id = rd_q;

endmodule

### src/tcea_ctrl.sv
// sequencer: applies one request, then admits one requester per iteration
`include "two_class_exclusive_admission_arbiter_macros.svh"

module tcea_ctrl import tcea_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH = 8,
	localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                command,
	input  logic                requester_class,
	input  logic [PortIdW-1:0]  requester_id,
	output logic                in_stall,
	input  logic [OccW-1:0]     cap,
	input  logic [CntW-1:0]     cnt_a,
	input  logic [CntW-1:0]     cnt_b,
	input  logic [ID_WIDTH-1:0] rd_a,
	input  logic [ID_WIDTH-1:0] rd_b,
	output fifo_cmd_t           cmd_a,
	output fifo_cmd_t           cmd_b,
	output logic [ID_WIDTH-1:0] wr_id,
	output emit_t               emit,
	input  logic                slot_free
);

	localparam int CmpW = (CntW > OccW) ? CntW : OccW;

	state_t              state_q, state_d;
	cmd_e_t              cmd_q;
	logic                cls_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [OccW-1:0]     occ_q;
	logic                hold_q;
	logic                turn_q;
	logic                sel_q;
	logic [OccW-1:0]     rem_q;
	logic                flag_q;
	evt_kind_t           flag_kind_q;
	logic [PortIdW-1:0]  flag_id_q;
	logic                flag_cls_q;

	logic                accept;
	logic                any_a, any_b, sel, full_cls;
	logic [CntW-1:0]     cnt_sel;
	logic [OccW-1:0]     cap_sat, room, n_adm;
	logic [CmpW-1:0]     room_w, cnt_w;
	logic                plan_go;
	logic [15:0]         req_wide, id_wide, rd_wide;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign req_wide = 16'(requester_id);
	assign id_wide  = 16'(id_q);
	assign rd_wide  = sel_q ? 16'(rd_b) : 16'(rd_a);

	assign any_a    = (cnt_a != '0);
	assign any_b    = (cnt_b != '0);
	assign full_cls = cls_q ? (cnt_b == CntW'(QUEUE_DEPTH)) : (cnt_a == CntW'(QUEUE_DEPTH));

	// empty resource: turn class first, else the other; occupied: holding class
	assign sel     = (occ_q == '0) ? (turn_q ? !any_a : any_b) : hold_q;
	assign cnt_sel = sel ? cnt_b : cnt_a;

	assign cap_sat = (cap > CapLimit) ? CapLimit : cap;
	assign room    = (cap_sat > occ_q) ? cap_sat - occ_q : '0;
	assign room_w  = CmpW'(room);
	assign cnt_w   = CmpW'(cnt_sel);
	assign n_adm   = OccW'((cnt_w < room_w) ? cnt_w : room_w);

	assign plan_go = !flag_q || slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_PLAN;
			end
			ST_PLAN: begin
				if (plan_go) state_d = (n_adm != '0) ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) state_d = (rem_q == OccW'(1)) ? ST_IDLE : ST_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		cmd_a    = '0;
		cmd_b    = '0;
		wr_id    = id_q;
		emit     = '0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_EXEC: begin
				if (cmd_q == CMD_ARRIVE && !full_cls) begin
					cmd_a.push = !cls_q;
					cmd_b.push = cls_q;
				end
			end
			ST_PLAN: begin
				emit.valid = flag_q;
				emit.kind  = flag_kind_q;
				emit.id    = flag_id_q;
				emit.cls   = flag_cls_q;
				emit.last  = (n_adm == '0);
			end
			ST_READ: begin
				cmd_a.pop = !sel_q;
				cmd_b.pop = sel_q;
			end
			ST_EMIT: begin
				emit.valid = 1'b1;
				emit.kind  = EVT_ADMIT;
				emit.id    = rd_wide[PortIdW-1:0];
				emit.cls   = sel_q;
				emit.last  = (rem_q == OccW'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_ARRIVE;
			cls_q       <= 1'b0;
			id_q        <= '0;
			occ_q       <= '0;
			hold_q      <= 1'b0;
			turn_q      <= 1'b1;
			sel_q       <= 1'b0;
			rem_q       <= '0;
			flag_q      <= 1'b0;
			flag_kind_q <= EVT_ADMIT;
			flag_id_q   <= '0;
			flag_cls_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= cmd_e_t'(command);
						cls_q <= requester_class;
						id_q  <= req_wide[ID_WIDTH-1:0];
					end
				end
				ST_EXEC: begin
					if (cmd_q == CMD_ARRIVE) begin
						if (full_cls) begin
							flag_q      <= 1'b1;
							flag_kind_q <= EVT_REJECT;
							flag_id_q   <= id_wide[PortIdW-1:0];
							flag_cls_q  <= cls_q;
						end
					end else if (occ_q == '0) begin
						flag_q      <= 1'b1;
						flag_kind_q <= EVT_LEAVE_EMPTY;
						flag_id_q   <= '0;
						flag_cls_q  <= 1'b0;
					end else begin
						occ_q <= occ_q - 1'b1;
						if (occ_q == OccW'(1)) hold_q <= 1'b0;
					end
				end
				ST_PLAN: begin
					if (plan_go) begin
						flag_q <= 1'b0;
						sel_q  <= sel;
						rem_q  <= n_adm;
						// turn flips once an empty resource picks a waiting class
						if (occ_q == '0 && (any_a || any_b)) turn_q <= !turn_q;
					end
				end
				ST_READ: begin
					occ_q  <= occ_q + 1'b1;
					hold_q <= sel_q;
				end
				ST_EMIT: begin
					if (slot_free) rem_q <= rem_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	`TCEA_ASSERT_NOW(a_admit_below_cap, state_q == ST_READ, occ_q < cap_sat, "admission beyond capacity")
	`TCEA_ASSERT_NOW(a_pop_not_empty, cmd_a.pop || cmd_b.pop, (sel_q ? any_b : any_a), "pop from empty queue")
	`TCEA_ASSERT_NOW(a_same_class, state_q == ST_READ && occ_q != '0, sel_q == hold_q, "admitting a second class")
	`TCEA_ASSERT_NEXT(a_last_ends_item, emit.valid && slot_free && emit.last, state_q == ST_IDLE, "last result without return to idle")

endmodule

### src/two_class_exclusive_admission_arbiter.sv
// Two-class exclusive admission arbiter: top level with capacity and result registers.
//
// Request channel (in_valid/in_stall): command 0 queues requester_id in the FIFO of
// requester_class, command 1 removes one occupant. in_stall is high while a request
// is being worked on; the block takes one request at a time.
// Result channel (out_valid/out_stall): a rejection (queue full) or a leave at empty
// comes first, then one result per admitted requester in queue order; last_result
// marks the final result of a request. A request with no effect gives no result.
// Sequence: after acceptance, the EXEC state applies the request, the PLAN state plans
// the admissions, then each admission passes the READ state (queue memory read) and
// the EMIT state (result load); with the reset capacity a request admits at most three.
// The single admission loop over the registered-read queue memory sets this order.
// Result stall: the result register holds its payload; the sequencer waits in place
// until the register frees and resumes with no loss.
// Configuration (cfg_valid/cfg_ready, capacity): write only while idle; values
// above sixteen act as sixteen. Reset (arst_n low): queues empty, resource empty,
// capacity 3, class A served first. Queue memories need no clearing pass.
module two_class_exclusive_admission_arbiter import tcea_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic               requester_class,
	input  logic [PortIdW-1:0] requester_id,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic [PortIdW-1:0] granted_id,
	output logic               granted_class,
	output logic               last_result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [OccW-1:0]    capacity
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic [OccW-1:0]     cap_q;
	logic                out_valid_q;
	evt_kind_t           out_kind_q;
	logic [PortIdW-1:0]  out_id_q;
	logic                out_cls_q;
	logic                out_last_q;
	logic                slot_free;
	emit_t               emit;
	fifo_cmd_t           cmd_a, cmd_b;
	logic [CntW-1:0]     cnt_a, cnt_b;
	logic [ID_WIDTH-1:0] rd_a, rd_b, wr_id;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit.valid) begin
			out_kind_q <= emit.kind;
			out_id_q   <= emit.id;
			out_cls_q  <= emit.cls;
			out_last_q <= emit.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = out_kind_q;
	assign granted_id    = out_id_q;
	assign granted_class = out_cls_q;
	assign last_result   = out_last_q;

	tcea_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH(ID_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.command(command),
		.requester_class(requester_class),
		.requester_id(requester_id),
		.in_stall(in_stall),
		.cap(cap_q),
		.cnt_a(cnt_a),
		.cnt_b(cnt_b),
		.rd_a(rd_a),
		.rd_b(rd_b),
		.cmd_a(cmd_a),
		.cmd_b(cmd_b),
		.wr_id(wr_id),
		.emit(emit),
		.slot_free(slot_free)
	);

	tcea_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH(ID_WIDTH)
	) u_fifo_a (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_a),
		.wr_id(wr_id),
		.count(cnt_a),
		.rd_id(rd_a)
	);

	tcea_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH(ID_WIDTH)
	) u_fifo_b (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_b),
		.wr_id(wr_id),
		.count(cnt_b),
		.rd_id(rd_b)
	);

endmodule
